@@ rtl/breakpoint_table_interpolator_assert.svh @@
// Assertion macros shared by the breakpoint table interpolator.
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define BTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define BTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bti_pkg.sv @@
// Types and constants shared by the breakpoint table interpolator modules.
package bti_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Width of the magnitudes of the 33-bit differences.
  localparam int unsigned MAG_W = 33;

  typedef struct packed {
    logic              opcode;
    logic [3:0]        entry_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] interpolated_y;
    logic              segment_found;
    logic              saturated;
  } out_word_t;

  // Search token handed from cell to cell along the chain.
  typedef struct packed {
    logic              vld;
    logic              found;
    logic              desc;
    logic signed [31:0] q;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } token_t;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [MAG_W-1:0] d;
  } div_req_t;

endpackage

@@ rtl/bti_cell.sv @@
// One breakpoint cell of the search chain: holds an (x, y) pair and tests one segment.
module bti_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic signed [31:0]  wr_x_i,
  input  logic signed [31:0]  wr_y_i,
  input  logic                check_en_i,
  input  bti_pkg::token_t     tok_i,
  output bti_pkg::token_t     tok_o,
  output logic signed [31:0]  point_x_o
);
  import bti_pkg::*;

  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic               vld_q;
  token_t             tok_d;
  token_t             tok_q;
  logic               hit;

  // The incoming token carries the previous breakpoint in its x1/y1 fields.
  always_comb begin
    if (tok_i.desc) begin
      hit = (tok_i.q <= tok_i.x1) && (tok_i.q > x_q);
    end else begin
      hit = (tok_i.q > tok_i.x1) && (tok_i.q <= x_q);
    end
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.found) begin
      tok_d.x0    = tok_i.x1;
      tok_d.y0    = tok_i.y1;
      tok_d.x1    = x_q;
      tok_d.y1    = y_q;
      tok_d.found = check_en_i && hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_en_i) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

  assign point_x_o = x_q;

endmodule

@@ rtl/bti_muldiv.sv @@
// Bit-serial unit that forms floor(a * b / d) for b <= d, one bit of a per cycle.
module bti_muldiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  bti_pkg::div_req_t             req_i,
  output logic                          done_o,
  output logic [bti_pkg::MAG_W-1:0]     quo_o
);
  import bti_pkg::*;

  localparam int unsigned CntW = $clog2(MAG_W + 1);
  localparam int unsigned RW   = MAG_W + 2;

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [MAG_W-1:0]  a_q;
  logic [MAG_W-1:0]  b_q;
  logic [MAG_W-1:0]  d_q;
  logic [MAG_W-1:0]  rem_q;
  logic [MAG_W-1:0]  quo_q;
  logic [MAG_W-1:0]  rem_d;
  logic [MAG_W-1:0]  quo_d;
  logic [RW-1:0]     r2;
  logic [RW-1:0]     d1;
  logic [RW-1:0]     d2;
  logic [1:0]        digit;

  // The remainder stays below d, so 2*rem + b stays below 3*d: a digit of 0, 1 or 2.
  always_comb begin
    r2 = {1'b0, rem_q, 1'b0} + (a_q[MAG_W-1] ? {2'b00, b_q} : RW'(0));
    d1 = {2'b00, d_q};
    d2 = {1'b0, d_q, 1'b0};
    if (r2 >= d2) begin
      digit = 2'd2;
      rem_d = MAG_W'(r2 - d2);
    end else if (r2 >= d1) begin
      digit = 2'd1;
      rem_d = MAG_W'(r2 - d1);
    end else begin
      digit = 2'd0;
      rem_d = MAG_W'(r2);
    end
    quo_d = MAG_W'({quo_q, 1'b0} + (MAG_W + 1)'(digit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      d_q   <= req_i.d;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[MAG_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/breakpoint_table_interpolator.sv @@
// Breakpoint table interpolator: a chain of breakpoint cells followed by a serial mul-divide.
// A write word goes straight to its cell. A query word walks the MAX_POINTS cells, one per cycle,
// then a 33-step bit-serial mul-divide runs, skipped when no segment holds the position.
// One query is in flight at a time.
// Reset clears points_in_use and all control state; breakpoint contents are undefined until written.
module breakpoint_table_interpolator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bti_pkg::in_word_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bti_pkg::out_word_t  out_o,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i
);
  import bti_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_POINTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [4:0]          pu_q;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q;
  out_word_t           res_q, res_d;
  token_t              seg_q;
  logic                neg_q;

  logic                in_acc;
  logic                is_query;
  logic [IdxW-1:0]     last_idx;
  logic                desc;
  token_t              tok_chain [MAX_POINTS+1];
  logic signed [31:0]  cell_x [MAX_POINTS];

  logic signed [32:0]  dy, dq, dx;
  div_req_t            div_req;
  logic                div_start;
  logic                div_done;
  logic [MAG_W-1:0]    div_quo;
  logic signed [34:0]  quo_s;
  logic signed [34:0]  sum;
  logic                sat;
  logic                load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_query   = (in_i.opcode == OP_QUERY);

  // Last breakpoint in use, with a count above the table taken as the full table.
  always_comb begin
    if (pu_q < 5'd2) begin
      last_idx = '0;
    end else if (32'(pu_q) > MAX_POINTS) begin
      last_idx = IdxW'(MAX_POINTS - 1);
    end else begin
      last_idx = IdxW'(32'(pu_q) - 32'd1);
    end
    desc = cell_x[0] > cell_x[last_idx];
  end

  always_comb begin
    tok_chain[0]       = '0;
    tok_chain[0].vld   = in_acc && is_query;
    tok_chain[0].desc  = desc;
    tok_chain[0].q     = in_i.query_x;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    bti_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (in_acc && !is_query && (32'(in_i.entry_index) == 32'(i))),
      .wr_x_i     (in_i.point_x),
      .wr_y_i     (in_i.point_y),
      .check_en_i ((i > 0) && (32'(pu_q) > 32'(i))),
      .tok_i      (tok_chain[i]),
      .tok_o      (tok_chain[i+1]),
      .point_x_o  (cell_x[i])
    );
  end

  // Differences of the matched segment; a hit guarantees x1 != x0 and |q - x0| <= |x1 - x0|.
  always_comb begin
    dy = {seg_q.y1[31], seg_q.y1} - {seg_q.y0[31], seg_q.y0};
    dq = {seg_q.q[31], seg_q.q} - {seg_q.x0[31], seg_q.x0};
    dx = {seg_q.x1[31], seg_q.x1} - {seg_q.x0[31], seg_q.x0};
    div_req.a = dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
    div_req.b = dq[32] ? MAG_W'(-dq) : MAG_W'(dq);
    div_req.d = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
  end

  assign div_start = (state_q == ST_PREP);

  bti_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    quo_s = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    sum   = $signed({{3{seg_q.y0[31]}}, seg_q.y0}) + quo_s;
    sat   = (sum[34:31] != 4'b0000) && (sum[34:31] != 4'b1111);
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_chain[MAX_POINTS].vld) begin
          if (tok_chain[MAX_POINTS].found) begin
            state_d = ST_PREP;
          end else begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.segment_found = 1'b1;
          res_d.saturated     = sat;
          if (!sat) begin
            res_d.interpolated_y = sum[31:0];
          end else if (sum[34]) begin
            res_d.interpolated_y = 32'sh8000_0000;
          end else begin
            res_d.interpolated_y = 32'sh7FFF_FFFF;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pu_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pu_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_SEARCH) begin
      seg_q <= tok_chain[MAX_POINTS];
    end
    if (state_q == ST_PREP) begin
      neg_q <= dy[32] ^ dq[32] ^ dx[32];
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `include "breakpoint_table_interpolator_assert.svh"

  `BTI_ASSERT_NXT(a_query_starts_search, in_acc && is_query, state_q == ST_SEARCH, "query word did not start the chain walk")
  `BTI_ASSERT_IMP(a_chain_only_in_search, tok_chain[MAX_POINTS].vld, state_q == ST_SEARCH, "search token left the chain outside the search phase")
  `BTI_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV, "mul-divide finished outside the divide phase")
  `BTI_ASSERT_IMP(a_miss_is_zero, out_valid_o && !out_o.segment_found, (out_o.interpolated_y == 32'sd0) && !out_o.saturated, "missed query gave a non-zero word")
  `BTI_ASSERT_IMP(a_sat_at_limit, out_valid_o && out_o.saturated, (out_o.interpolated_y == 32'sh7FFF_FFFF) || (out_o.interpolated_y == 32'sh8000_0000), "saturated word is not at a limit")

endmodule
